@@ rtl/bldc_six_step_commutator_assert.svh @@
// Assertion macros for the six-step commutator.
`ifndef BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH

// same-cycle implication
`define BSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("six-step commutator check failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("six-step commutator check failed");

`endif

@@ rtl/bldc_pkg.sv @@
// Types, codes and commutation tables for the six-step commutator.
package bldc_pkg;

    localparam int PERIOD_W    = 16;
    localparam int CMP_W       = 16;
    localparam int DUTY_OUT_W  = 14;
    localparam int NUM_CH      = 6;
    localparam int RECIP_SHIFT = 32;

    localparam logic [2:0] CMD_HALL_STEP  = 3'd0;
    localparam logic [2:0] CMD_NEXT_STEP  = 3'd1;
    localparam logic [2:0] CMD_STOP       = 3'd2;
    localparam logic [2:0] CMD_RESET_SEQ  = 3'd3;
    localparam logic [2:0] CMD_SET_DUTY   = 3'd4;

    localparam logic [1:0] ROT_STOP = 2'd0;
    localparam logic [1:0] ROT_FWD  = 2'd1;
    localparam logic [1:0] ROT_REV  = 2'd2;

    localparam logic [2:0] HALL_MIN = 3'd1;
    localparam logic [2:0] HALL_MAX = 3'd6;
    localparam logic [2:0] SEQ_LAST = 3'd5;

    localparam logic [2:0] CH_UH = 3'd0;
    localparam logic [2:0] CH_UL = 3'd1;
    localparam logic [2:0] CH_VH = 3'd2;
    localparam logic [2:0] CH_VL = 3'd3;
    localparam logic [2:0] CH_WH = 3'd4;
    localparam logic [2:0] CH_WL = 3'd5;

    localparam logic [2:0] FWD_HIGH [8] = '{3'd0, 3'd2, 3'd4, 3'd2, 3'd0, 3'd0, 3'd4, 3'd0};
    localparam logic [2:0] FWD_LOW  [8] = '{3'd0, 3'd5, 3'd1, 3'd1, 3'd3, 3'd5, 3'd3, 3'd0};
    localparam logic [2:0] REV_HIGH [8] = '{3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd0, 3'd4, 3'd0};
    localparam logic [2:0] REV_LOW  [8] = '{3'd0, 3'd5, 3'd1, 3'd5, 3'd3, 3'd3, 3'd1, 3'd0};
    localparam logic [2:0] SEQ_FWD  [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
    localparam logic [2:0] SEQ_REV  [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    typedef struct packed {
        logic [2:0]          cmd;
        logic [2:0]          hall_code;
        logic [1:0]          rotation;
        logic [PERIOD_W-1:0] duty_request;
    } in_word_t;

    typedef struct packed {
        logic [CMP_W-1:0]      cmp_uh;
        logic [CMP_W-1:0]      cmp_ul;
        logic [CMP_W-1:0]      cmp_vh;
        logic [CMP_W-1:0]      cmp_vl;
        logic [CMP_W-1:0]      cmp_wh;
        logic [CMP_W-1:0]      cmp_wl;
        logic [DUTY_OUT_W-1:0] duty_now;
        logic                  compares_written;
    } out_word_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] hall_code;
        logic [1:0] rotation;
    } op_ctrl_t;

    function automatic logic [2:0] high_chan(input logic rev, input logic [2:0] hall);
        return rev ? REV_HIGH[hall] : FWD_HIGH[hall];
    endfunction

    function automatic logic [2:0] low_chan(input logic rev, input logic [2:0] hall);
        return rev ? REV_LOW[hall] : FWD_LOW[hall];
    endfunction

    function automatic logic [2:0] seq_hall(input logic rev, input logic [2:0] idx);
        return rev ? SEQ_REV[idx] : SEQ_FWD[idx];
    endfunction

endpackage

@@ rtl/bldc_six_step_commutator.sv @@
// Six-step commutator: six-stage pipeline from input word to result word.
// Throughput: one word per cycle while m_ready does not stall the output; the
// compare value period*duty/full-scale runs through a product, reciprocal
// multiply and correction stage ahead of the commutation stage. Synchronous
// active-low reset clears all compares, the sequence state, the duty and the
// period register, and empties the pipe.
module bldc_six_step_commutator #(
    parameter int DUTY_FULL_SCALE = 10000
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bldc_pkg::PERIOD_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bldc_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bldc_pkg::out_word_t            m_data
);
    import bldc_pkg::*;

    localparam int    NSTG    = 5;
    localparam int    DW      = $clog2(DUTY_FULL_SCALE + 1);
    localparam int    PW      = PERIOD_W + DW;
    localparam longint RECIP  = (64'd1 << RECIP_SHIFT) / DUTY_FULL_SCALE;
    localparam int    MW      = $clog2(RECIP + 1);
    localparam int    RW      = PW + MW;
    localparam logic [MW-1:0] RECIP_K = MW'(RECIP);
    localparam logic [DW-1:0] FULL_K  = DW'(DUTY_FULL_SCALE);

    logic [PERIOD_W-1:0]  period_reg;
    logic [DW-1:0]        duty_front_reg;
    logic [DW-1:0]        duty_front_next;
    logic [DW-1:0]        duty_clamp;

    logic [NSTG:0]        take;
    logic [NSTG-1:0]      valid_reg;
    op_ctrl_t             ctrl_reg [NSTG];
    logic [DW-1:0]        duty_reg [NSTG];

    logic [PW-1:0]        product_reg;
    logic [RW-1:0]        recip_reg;
    logic [PW-1:0]        prod2_reg;
    logic [PW-1:0]        prod3_reg;
    logic [CMP_W-1:0]     est_reg;
    logic [PW-1:0]        back_reg;
    logic [CMP_W-1:0]     quot_reg;
    logic [RW-1:0]        recip_shifted;
    logic [CMP_W-1:0]     est_now;
    logic [PW-1:0]        rem;
    logic                 rem_ge;

    logic                 m_valid_reg;
    logic [DUTY_OUT_W-1:0] m_duty_reg;
    logic                 m_wrote_reg;
    logic [NUM_CH-1:0][CMP_W-1:0] cmp_reg;
    logic [NUM_CH-1:0][CMP_W-1:0] cmp_next;
    logic [2:0]           last_hall_reg;
    logic [2:0]           last_hall_next;
    logic [1:0]           last_rot_reg;
    logic [1:0]           last_rot_next;
    logic [2:0]           seq_reg;
    logic [2:0]           seq_next;
    logic [2:0]           seq_adv;
    logic                 wrote_next;
    logic                 apply_hall;
    logic [2:0]           apply_code;
    logic                 hall_ok;
    logic                 use_rev;
    logic [2:0]           hi_ch;
    logic [2:0]           lo_ch;
    logic                 out_free;
    logic                 out_exec;
    op_ctrl_t             exec_ctrl;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    // duty tracks accepted words in order
    always_comb begin
        if (s_data.duty_request > PERIOD_W'(DUTY_FULL_SCALE)) begin
            duty_clamp = FULL_K;
        end else begin
            duty_clamp = DW'(s_data.duty_request);
        end
        duty_front_next = (s_data.cmd == CMD_SET_DUTY) ? duty_clamp : duty_front_reg;
    end

    // stage handshake
    always_comb begin
        int k;
        take[NSTG] = out_free;
        for (k = NSTG - 1; k >= 0; k--) begin
            take[k] = !valid_reg[k] || take[k+1];
        end
    end

    assign s_ready  = take[0];
    assign out_free = !m_valid_reg || m_ready;
    assign out_exec = out_free && valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            duty_front_reg <= '0;
        end else begin
            if (take[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (take[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (s_valid && take[0]) begin
                duty_front_reg <= duty_front_next;
            end
        end
    end

    // divide by full scale: reciprocal estimate, then one correction step
    assign recip_shifted = recip_reg >> RECIP_SHIFT;
    assign est_now       = recip_shifted[CMP_W-1:0];
    assign rem           = prod3_reg - back_reg;
    assign rem_ge        = rem >= PW'(FULL_K);

    always_ff @(posedge aclk) begin
        if (s_valid && take[0]) begin
            ctrl_reg[0] <= '{cmd: s_data.cmd, hall_code: s_data.hall_code,
                             rotation: s_data.rotation};
            duty_reg[0] <= duty_front_next;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (take[k] && valid_reg[k-1]) begin
                ctrl_reg[k] <= ctrl_reg[k-1];
                duty_reg[k] <= duty_reg[k-1];
            end
        end
        if (take[1] && valid_reg[0]) begin
            product_reg <= PW'(period_reg) * PW'(duty_reg[0]);
        end
        if (take[2] && valid_reg[1]) begin
            recip_reg <= RW'(product_reg) * RW'(RECIP_K);
            prod2_reg <= product_reg;
        end
        if (take[3] && valid_reg[2]) begin
            est_reg   <= est_now;
            back_reg  <= PW'(est_now) * PW'(FULL_K);
            prod3_reg <= prod2_reg;
        end
        if (take[4] && valid_reg[3]) begin
            quot_reg <= est_reg + CMP_W'(rem_ge);
        end
    end

    // commutation
    assign exec_ctrl = ctrl_reg[NSTG-1];
    assign seq_adv   = (seq_reg == SEQ_LAST) ? 3'd0 : seq_reg + 3'd1;

    always_comb begin
        cmp_next       = cmp_reg;
        last_hall_next = last_hall_reg;
        last_rot_next  = last_rot_reg;
        seq_next       = seq_reg;
        wrote_next     = 1'b0;
        apply_hall     = 1'b0;
        apply_code     = exec_ctrl.hall_code;
        unique case (exec_ctrl.cmd)
            CMD_HALL_STEP: begin
                apply_hall = 1'b1;
            end
            CMD_NEXT_STEP: begin
                if (exec_ctrl.rotation == ROT_FWD || exec_ctrl.rotation == ROT_REV) begin
                    seq_next   = seq_adv;
                    apply_hall = 1'b1;
                    apply_code = seq_hall(exec_ctrl.rotation == ROT_REV, seq_adv);
                end else begin
                    cmp_next       = '0;
                    last_hall_next = 3'd0;
                    last_rot_next  = ROT_STOP;
                    seq_next       = 3'd0;
                    wrote_next     = 1'b1;
                end
            end
            CMD_STOP: begin
                cmp_next       = '0;
                last_hall_next = 3'd0;
                last_rot_next  = ROT_STOP;
                seq_next       = 3'd0;
                wrote_next     = 1'b1;
            end
            CMD_RESET_SEQ: begin
                last_hall_next = 3'd0;
                last_rot_next  = ROT_STOP;
                seq_next       = 3'd0;
            end
            default: begin
            end
        endcase
        hall_ok = apply_hall && apply_code >= HALL_MIN && apply_code <= HALL_MAX
                  && !(apply_code == last_hall_reg && exec_ctrl.rotation == last_rot_reg);
        use_rev = exec_ctrl.rotation != ROT_FWD;
        hi_ch   = high_chan(use_rev, apply_code);
        lo_ch   = low_chan(use_rev, apply_code);
        if (hall_ok) begin
            last_hall_next = apply_code;
            last_rot_next  = exec_ctrl.rotation;
            cmp_next       = '0;
            wrote_next     = 1'b1;
            if (exec_ctrl.rotation != ROT_STOP) begin
                cmp_next[hi_ch] = quot_reg;
                cmp_next[lo_ch] = quot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            cmp_reg       <= '0;
            last_hall_reg <= 3'd0;
            last_rot_reg  <= ROT_STOP;
            seq_reg       <= 3'd0;
        end else begin
            if (out_free) begin
                m_valid_reg <= valid_reg[NSTG-1];
            end
            if (out_exec) begin
                cmp_reg       <= cmp_next;
                last_hall_reg <= last_hall_next;
                last_rot_reg  <= last_rot_next;
                seq_reg       <= seq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_exec) begin
            m_duty_reg  <= DUTY_OUT_W'(duty_reg[NSTG-1]);
            m_wrote_reg <= wrote_next;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_data.cmp_uh           = cmp_reg[CH_UH];
    assign m_data.cmp_ul           = cmp_reg[CH_UL];
    assign m_data.cmp_vh           = cmp_reg[CH_VH];
    assign m_data.cmp_vl           = cmp_reg[CH_VL];
    assign m_data.cmp_wh           = cmp_reg[CH_WH];
    assign m_data.cmp_wl           = cmp_reg[CH_WL];
    assign m_data.duty_now         = m_duty_reg;
    assign m_data.compares_written = m_wrote_reg;

`include "bldc_six_step_commutator_assert.svh"

    `BSC_ASSERT_NOW(a_quot_range, valid_reg[NSTG-1], quot_reg <= period_reg)
    `BSC_ASSERT_NEXT(a_keep_cmp, out_exec && !wrote_next, $stable(cmp_reg))
    `BSC_ASSERT_NEXT(a_stop_clears, out_exec && exec_ctrl.cmd == CMD_STOP, {cmp_reg, seq_reg} == '0)

endmodule
